// ===== rtl/osp_pkg.sv =====
// shared types and constants for the oled shadow pixel writer
// no dependencies; used by every module of the block by scoped name
package osp_pkg;

  // display geometry
  localparam int PAGES   = 8;
  localparam int COLUMNS = 128;
  localparam int PAGE_W  = $clog2(PAGES);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ADDR_W  = $clog2(PAGES * COLUMNS);

  // controller command bytes
  localparam logic [7:0] PAGE_BASE = 8'hB0;
  localparam logic [7:0] COL_HI    = 8'h10;
  localparam logic [7:0] NIB_MASK  = 8'h0F;

  // result buffer sizing: one operation emits at most this many beats
  localparam int MAX_BEATS  = 4;
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // operation codes on the input channel
  typedef enum logic [2:0] {
    CMD_SET_PAGE  = 3'd0,
    CMD_SET_COL   = 3'd1,
    CMD_WR_DATA   = 3'd2,
    CMD_SET_PIX   = 3'd3,
    CMD_CLR_PIX   = 3'd4,
    CMD_INV_PIX   = 3'd5
  } cmd_e;

  // classified operation handed from front to back
  typedef struct packed {
    cmd_e               cmd;
    logic [PAGE_W-1:0]  page;
    logic [COL_W-1:0]   col;
    logic [2:0]         bit_sel;
    logic [7:0]         data;
  } op_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } beat_t;

  // shadow memory address of a page and column
  function automatic logic [ADDR_W-1:0] ram_addr(input logic [PAGE_W-1:0] page,
                                                 input logic [COL_W-1:0]  col);
    ram_addr = ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/osp_front.sv =====
// front part: accepts input beats, classifies them and holds them in a short op queue
// depends on osp_pkg
module osp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          cmd_i,
  input  logic [2:0]          page_num_i,
  input  logic [6:0]          column_i,
  input  logic [5:0]          row_i,
  input  logic [7:0]          data_byte_i,
  input  logic                back_busy_i,
  output logic                op_valid_o,
  output osp_pkg::op_t        op_o,
  input  logic                op_pop_i
);

  osp_pkg::op_t op_in;
  logic         known;
  logic         accept;
  logic         wr_en;
  osp_pkg::op_t queue_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  // classify the incoming operation
  always_comb begin
    op_in         = '0;
    op_in.cmd     = osp_pkg::CMD_SET_PAGE;
    op_in.data    = data_byte_i;
    op_in.bit_sel = row_i[2:0];
    op_in.col     = osp_pkg::COL_W'(32'(column_i) % osp_pkg::COLUMNS);
    known         = 1'b1;
    case (cmd_i)
      osp_pkg::CMD_SET_PAGE: begin
        op_in.cmd  = osp_pkg::CMD_SET_PAGE;
        op_in.page = osp_pkg::PAGE_W'(32'(page_num_i) % osp_pkg::PAGES);
      end
      osp_pkg::CMD_SET_COL: begin
        op_in.cmd = osp_pkg::CMD_SET_COL;
      end
      osp_pkg::CMD_WR_DATA: begin
        op_in.cmd = osp_pkg::CMD_WR_DATA;
      end
      osp_pkg::CMD_SET_PIX, osp_pkg::CMD_CLR_PIX, osp_pkg::CMD_INV_PIX: begin
        op_in.cmd  = osp_pkg::cmd_e'(cmd_i);
        op_in.page = osp_pkg::PAGE_W'(32'(row_i[5:3]) % osp_pkg::PAGES);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // handshake; unused codes are taken and dropped
  assign full   = (count_q == 2'd2) || back_busy_i;
  assign accept = push && !full;
  assign wr_en  = accept && known;

  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = queue_q[rd_ptr_q];

  // queue pointers
  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = op_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(wr_en) - 2'(op_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

// ===== rtl/osp_back.sv =====
// back part: shadow memory, cursor and the sequencer that emits controller beats
// depends on osp_pkg; clears the shadow memory after reset
module osp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  osp_pkg::op_t  op_i,
  output logic          op_pop_o,
  output logic          busy_o,
  input  logic          out_room_i,
  output logic          beat_valid_o,
  output osp_pkg::beat_t beat_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAGE,
    ST_COL_LO,
    ST_COL_HI,
    ST_DATA
  } state_e;

  state_e                      state_q, state_d;
  logic [osp_pkg::PAGE_W-1:0]  cur_page_q, cur_page_d;
  logic [osp_pkg::COL_W-1:0]   cur_col_q, cur_col_d;
  logic [osp_pkg::ADDR_W-1:0]  clr_q, clr_d;
  osp_pkg::op_t                op_q;
  logic                        is_pixel;
  logic [7:0]                  mask;
  logic [7:0]                  pix_val;

  logic [7:0]                  mem [osp_pkg::PAGES * osp_pkg::COLUMNS];
  logic [7:0]                  rdata_q;
  logic                        mem_we;
  logic [osp_pkg::ADDR_W-1:0]  mem_waddr;
  logic [7:0]                  mem_wdata;

  assign is_pixel = (op_q.cmd == osp_pkg::CMD_SET_PIX) ||
                    (op_q.cmd == osp_pkg::CMD_CLR_PIX) ||
                    (op_q.cmd == osp_pkg::CMD_INV_PIX);

  // pixel read-modify on the registered shadow byte
  always_comb begin
    mask = 8'd1 << op_q.bit_sel;
    case (op_q.cmd)
      osp_pkg::CMD_SET_PIX: pix_val = rdata_q | mask;
      osp_pkg::CMD_CLR_PIX: pix_val = rdata_q & ~mask;
      default:              pix_val = rdata_q ^ mask;
    endcase
  end

  assign busy_o   = (state_q == ST_CLEAR);
  assign op_pop_o = (state_q == ST_IDLE) && op_valid_i && out_room_i;

  // sequencer next state, beat and memory write
  always_comb begin
    state_d      = state_q;
    cur_page_d   = cur_page_q;
    cur_col_d    = cur_col_q;
    clr_d        = clr_q;
    beat_valid_o = 1'b0;
    beat_o       = '0;
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = 8'd0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == osp_pkg::ADDR_W'(osp_pkg::PAGES * osp_pkg::COLUMNS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_pop_o) begin
          case (op_i.cmd)
            osp_pkg::CMD_SET_COL: state_d = ST_COL_LO;
            osp_pkg::CMD_WR_DATA: state_d = ST_DATA;
            default:              state_d = ST_PAGE;
          endcase
        end
      end
      ST_PAGE: begin
        beat_valid_o     = 1'b1;
        beat_o.out_byte  = osp_pkg::PAGE_BASE | 8'(op_q.page);
        beat_o.last      = !is_pixel;
        cur_page_d       = op_q.page;
        state_d          = is_pixel ? ST_COL_LO : ST_IDLE;
      end
      ST_COL_LO: begin
        beat_valid_o    = 1'b1;
        beat_o.out_byte = 8'(op_q.col) & osp_pkg::NIB_MASK;
        cur_col_d       = op_q.col;
        state_d         = ST_COL_HI;
      end
      ST_COL_HI: begin
        beat_valid_o    = 1'b1;
        beat_o.out_byte = osp_pkg::COL_HI | 8'(op_q.col >> 4);
        beat_o.last     = !is_pixel;
        state_d         = is_pixel ? ST_DATA : ST_IDLE;
      end
      ST_DATA: begin
        beat_valid_o    = 1'b1;
        beat_o.out_byte = op_q.data;
        beat_o.is_data  = 1'b1;
        beat_o.last     = 1'b1;
        mem_we          = 1'b1;
        mem_waddr       = osp_pkg::ram_addr(cur_page_q, cur_col_q);
        mem_wdata       = op_q.data;
        if (cur_col_q == osp_pkg::COL_W'(osp_pkg::COLUMNS - 1)) begin
          cur_col_d = '0;
        end else begin
          cur_col_d = cur_col_q + 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cur_page_q <= '0;
      cur_col_q  <= '0;
      clr_q      <= '0;
    end else begin
      state_q    <= state_d;
      cur_page_q <= cur_page_d;
      cur_col_q  <= cur_col_d;
      clr_q      <= clr_d;
    end
  end

  // operation register; pixel ops pick up the modified byte in the page step
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end else if (state_q == ST_PAGE && is_pixel) begin
      op_q.data <= pix_val;
    end
  end

  // shadow memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (op_pop_o) begin
      rdata_q <= mem[osp_pkg::ram_addr(op_i.page, op_i.col)];
    end
  end

endmodule

// ===== rtl/osp_out_fifo.sv =====
// result buffer between the back part and the result channel
// depends on osp_pkg
module osp_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  osp_pkg::beat_t wr_beat_i,
  output logic           room_o,
  output logic           empty,
  input  logic           pop,
  output osp_pkg::beat_t rd_beat_o
);

  osp_pkg::beat_t                buf_q [osp_pkg::OUT_DEPTH];
  logic [osp_pkg::OUT_PTR_W-1:0] wr_ptr_q;
  logic [osp_pkg::OUT_PTR_W-1:0] rd_ptr_q;
  logic [osp_pkg::OUT_CNT_W-1:0] count_q, count_d;
  logic                          rd_en;

  assign empty     = (count_q == '0);
  assign rd_en     = pop && !empty;
  assign rd_beat_o = buf_q[rd_ptr_q];
  // room for a whole operation's beats
  assign room_o    = (count_q <= osp_pkg::OUT_CNT_W'(osp_pkg::OUT_DEPTH - osp_pkg::MAX_BEATS));

  always_comb begin
    count_d = count_q + osp_pkg::OUT_CNT_W'(wr_en_i) - osp_pkg::OUT_CNT_W'(rd_en);
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      buf_q[wr_ptr_q] <= wr_beat_i;
    end
  end

endmodule

// ===== rtl/oled_shadow_pixel_writer.sv =====
// top level of the oled shadow pixel writer: front, back and result buffer
// depends on osp_pkg, osp_front, osp_back and osp_out_fifo
//
// usage:
// - input channel is a queue write: a beat is taken when push is high and
//   full is low; fields cmd_i, page_num_i, column_i, row_i, data_byte_i
// - result channel is a queue read: the oldest byte sits on out_byte_o,
//   is_data_o and last_o while empty is low and is taken when pop is high
// - set page gives one command beat, set column two, write data one data
//   beat, a pixel op four (page, column low, column high, data); last_o marks
//   the final beat of an operation; codes 6 and 7 are taken and give nothing
// - an accepted op goes through the op queue and sequencer into the result buffer
// - throughput: the back sequencer emits one beat per cycle once an op is
//   issued from idle, which waits for room in the result buffer; a
//   two-entry op queue lets the front keep taking beats
// - after reset the shadow memory is zeroed, one byte a cycle, across all
//   1024 bytes; full stays high until that pass is done
// - when the receiver stalls, the 8-beat result buffer fills, the back part
//   waits for room for a whole operation, then the op queue fills and full rises
module oled_shadow_pixel_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] cmd_i,
  input  logic [2:0] page_num_i,
  input  logic [6:0] column_i,
  input  logic [5:0] row_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  logic           back_busy;
  logic           op_valid;
  osp_pkg::op_t   op;
  logic           op_pop;
  logic           out_room;
  logic           beat_valid;
  osp_pkg::beat_t beat;
  osp_pkg::beat_t rd_beat;

  // accept and classify
  osp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .page_num_i  (page_num_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .data_byte_i (data_byte_i),
    .back_busy_i (back_busy),
    .op_valid_o  (op_valid),
    .op_o        (op),
    .op_pop_i    (op_pop)
  );

  // carry out operations against the shadow memory
  osp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (op_valid),
    .op_i         (op),
    .op_pop_o     (op_pop),
    .busy_o       (back_busy),
    .out_room_i   (out_room),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  // result buffer
  osp_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (beat_valid),
    .wr_beat_i (beat),
    .room_o    (out_room),
    .empty     (empty),
    .pop       (pop),
    .rd_beat_o (rd_beat)
  );

  assign out_byte_o = rd_beat.out_byte;
  assign is_data_o  = rd_beat.is_data;
  assign last_o     = rd_beat.last;

endmodule

// ===== verif/oled_shadow_pixel_writer_test.sv =====
// self-checking testbench for oled_shadow_pixel_writer: directed table, then random ops
// depends on osp_pkg and the rtl of the block; predicts the byte stream from its own shadow copy
`timescale 1ns / 1ps

module oled_shadow_pixel_writer_test;

  // opcodes the block takes and drops
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  localparam int ITEMS_PER_PHASE = 108;
  localparam int DRAIN_CYCLES    = 20;

  // one directed op; beats are typed in only where typed is set
  typedef struct packed {
    logic [2:0]              op;
    logic [2:0]              pg;
    logic [6:0]              col;
    logic [5:0]              row;
    logic [7:0]              dat;
    logic                    typed;
    logic [2:0]              n_beats;
    osp_pkg::beat_t [0:3]    beats;
  } stim_row_t;

  localparam osp_pkg::beat_t NB = '0;
  localparam int N_DIRECTED = 23;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // data write right after reset, cursor at page 0 column 0
    '{osp_pkg::CMD_WR_DATA, 3'd0, 7'd0, 6'd0, 8'hFF, 1'b1, 3'd1,
      '{{8'hFF, 1'b1, 1'b1}, NB, NB, NB}},
    // page extremes
    '{osp_pkg::CMD_SET_PAGE, 3'd7, 7'd0, 6'd0, 8'h00, 1'b1, 3'd1,
      '{{8'hB7, 1'b0, 1'b1}, NB, NB, NB}},
    '{osp_pkg::CMD_SET_PAGE, 3'd0, 7'd127, 6'd63, 8'hFF, 1'b1, 3'd1,
      '{{8'hB0, 1'b0, 1'b1}, NB, NB, NB}},
    // last column, then a write there wraps the cursor to column 0
    '{osp_pkg::CMD_SET_COL, 3'd7, 7'd127, 6'd0, 8'h00, 1'b1, 3'd2,
      '{{8'h0F, 1'b0, 1'b0}, {8'h17, 1'b0, 1'b1}, NB, NB}},
    '{osp_pkg::CMD_WR_DATA, 3'd0, 7'd0, 6'd0, 8'h00, 1'b1, 3'd1,
      '{{8'h00, 1'b1, 1'b1}, NB, NB, NB}},
    '{osp_pkg::CMD_WR_DATA, 3'd0, 7'd0, 6'd0, 8'hA5, 1'b1, 3'd1,
      '{{8'hA5, 1'b1, 1'b1}, NB, NB, NB}},
    // pixel at the far corner of a cleared shadow
    '{osp_pkg::CMD_SET_PIX, 3'd0, 7'd127, 6'd63, 8'h00, 1'b1, 3'd4,
      '{{8'hB7, 1'b0, 1'b0}, {8'h0F, 1'b0, 1'b0}, {8'h17, 1'b0, 1'b0},
        {8'h80, 1'b1, 1'b1}}},
    '{osp_pkg::CMD_CLR_PIX, 3'd0, 7'd127, 6'd63, 8'hFF, 1'b1, 3'd4,
      '{{8'hB7, 1'b0, 1'b0}, {8'h0F, 1'b0, 1'b0}, {8'h17, 1'b0, 1'b0},
        {8'h00, 1'b1, 1'b1}}},
    // read-modify-write on bytes written earlier
    '{osp_pkg::CMD_INV_PIX, 3'd0, 7'd0, 6'd0, 8'h00, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_INV_PIX, 3'd7, 7'd0, 6'd0, 8'hFF, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_SET_PIX, 3'd0, 7'd0, 6'd7, 8'h00, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_CLR_PIX, 3'd0, 7'd0, 6'd2, 8'h00, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    // unused opcodes give nothing and leave the cursor alone
    '{CMD_UNUSED_6, 3'd7, 7'd127, 6'd63, 8'hFF, 1'b1, 3'd0, '{NB, NB, NB, NB}},
    '{CMD_UNUSED_7, 3'd0, 7'd0, 6'd0, 8'h00, 1'b1, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_WR_DATA, 3'd7, 7'd127, 6'd63, 8'h55, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_SET_PIX, 3'd0, 7'd64, 6'd32, 8'h00, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_INV_PIX, 3'd0, 7'd64, 6'd39, 8'h00, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_SET_COL, 3'd0, 7'd0, 6'd63, 8'hFF, 1'b1, 3'd2,
      '{{8'h00, 1'b0, 1'b0}, {8'h10, 1'b0, 1'b1}, NB, NB}},
    '{osp_pkg::CMD_SET_PAGE, 3'd5, 7'd127, 6'd63, 8'hFF, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_WR_DATA, 3'd0, 7'd0, 6'd0, 8'hAA, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    // wrap within a page other than 0
    '{osp_pkg::CMD_SET_COL, 3'd0, 7'd127, 6'd0, 8'h00, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_WR_DATA, 3'd0, 7'd0, 6'd0, 8'h3C, 1'b0, 3'd0, '{NB, NB, NB, NB}},
    '{osp_pkg::CMD_WR_DATA, 3'd0, 7'd0, 6'd0, 8'hC3, 1'b0, 3'd0, '{NB, NB, NB, NB}}
  };

  // clock, reset and block ports
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [2:0] cmd_i       = '0;
  logic [2:0] page_num_i  = '0;
  logic [6:0] column_i    = '0;
  logic [5:0] row_i       = '0;
  logic [7:0] data_byte_i = '0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       last_o;

  // typed expectation travelling with the current op
  logic                 row_typed = 1'b0;
  logic [2:0]           row_n     = '0;
  osp_pkg::beat_t [0:3] row_beats = '0;

  // idle rates in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  // predictor state
  logic [7:0]                 shadow_mem [osp_pkg::PAGES*osp_pkg::COLUMNS] = '{default: '0};
  logic [osp_pkg::PAGE_W-1:0] cur_page = '0;
  logic [osp_pkg::COL_W-1:0]  cur_col  = '0;
  osp_pkg::beat_t             predicted [$];
  osp_pkg::beat_t             pending_bytes [$];
  int                         errors = 0;

  oled_shadow_pixel_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .page_num_i  (page_num_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // page command, moves the cursor page
  function automatic void emit_page(input logic [osp_pkg::PAGE_W-1:0] pg);
    cur_page = pg;
    predicted.push_back({osp_pkg::PAGE_BASE | 8'(pg), 1'b0, 1'b0});
  endfunction

  // column low and high nibble commands, moves the cursor column
  function automatic void emit_col(input logic [osp_pkg::COL_W-1:0] col);
    cur_col = col;
    predicted.push_back({8'(col) & osp_pkg::NIB_MASK, 1'b0, 1'b0});
    predicted.push_back({osp_pkg::COL_HI | 8'(col >> 4), 1'b0, 1'b0});
  endfunction

  // data byte stored at the cursor; column counter wraps at COLUMNS by width
  function automatic void emit_data(input logic [7:0] b);
    shadow_mem[int'(cur_page) * osp_pkg::COLUMNS + int'(cur_col)] = b;
    cur_col = cur_col + 1'b1;
    predicted.push_back({b, 1'b1, 1'b0});
  endfunction

  // byte stream and state change of one accepted op
  function automatic void predict_stream(input logic [2:0] op, input logic [2:0] pg_in,
                                         input logic [6:0] col_in, input logic [5:0] row_in,
                                         input logic [7:0] dat_in);
    logic [7:0] val;
    logic [7:0] mask;
    predicted.delete();
    mask = 8'd1 << row_in[2:0];
    val  = shadow_mem[int'(row_in[5:3]) * osp_pkg::COLUMNS + int'(col_in)];
    case (op)
      osp_pkg::CMD_SET_PAGE: emit_page(pg_in);
      osp_pkg::CMD_SET_COL:  emit_col(col_in);
      osp_pkg::CMD_WR_DATA:  emit_data(dat_in);
      osp_pkg::CMD_SET_PIX, osp_pkg::CMD_CLR_PIX, osp_pkg::CMD_INV_PIX: begin
        if (op == osp_pkg::CMD_SET_PIX) val = val | mask;
        else if (op == osp_pkg::CMD_CLR_PIX) val = val & ~mask;
        else val = val ^ mask;
        emit_page(row_in[5:3]);
        emit_col(col_in);
        emit_data(val);
      end
      default: ;
    endcase
  endfunction

  // result check first, then expectations of the op taken at this edge
  always @(posedge clk_i) begin
    osp_pkg::beat_t want;
    osp_pkg::beat_t got;
    got = {out_byte_o, is_data_o, last_o};
    if (rst_ni && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: byte %02h data %0b last %0b",
                   got.out_byte, got.is_data, got.last);
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
            got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected byte %02h data %0b last %0b, ",
                      "got byte %02h data %0b last %0b"},
                     want.out_byte, want.is_data, want.last,
                     got.out_byte, got.is_data, got.last);
        end
      end
    end
    if (rst_ni && push && !full) begin
      predict_stream(cmd_i, page_num_i, column_i, row_i, data_byte_i);
      if (row_typed) begin
        for (int i = 0; i < int'(row_n); i++) pending_bytes.push_back(row_beats[i]);
      end else begin
        for (int i = 0; i < predicted.size(); i++) begin
          want = predicted[i];
          want.last = (i == predicted.size() - 1);
          pending_bytes.push_back(want);
        end
      end
    end
  end

  // receiver side stalls
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // one op on the input queue, with a random gap first; waits for acceptance
  task automatic drive_op(input logic [2:0] op, input logic [2:0] pg, input logic [6:0] col,
                          input logic [5:0] row, input logic [7:0] dat, input logic typed,
                          input logic [2:0] n_beats, input osp_pkg::beat_t [0:3] beats);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    cmd_i       <= op;
    page_num_i  <= pg;
    column_i    <= col;
    row_i       <= row;
    data_byte_i <= dat;
    row_typed   <= typed;
    row_n       <= n_beats;
    row_beats   <= beats;
    if (!push) push <= 1'b1;
    do @(posedge clk_i); while (full);
  endtask

  // stimulus
  initial begin
    int         counted;
    int         sel;
    logic [2:0] op;
    logic [6:0] col;
    logic [5:0] row;
    int         idle_by_phase [4];
    int         stall_by_phase [4];
    idle_by_phase  = '{0, 52, 0, 31};
    stall_by_phase = '{0, 0, 52, 31};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      drive_op(DIRECTED[i].op, DIRECTED[i].pg, DIRECTED[i].col, DIRECTED[i].row,
               DIRECTED[i].dat, DIRECTED[i].typed, DIRECTED[i].n_beats, DIRECTED[i].beats);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      counted   = 0;
      while (counted < ITEMS_PER_PHASE) begin
        sel = $urandom_range(99);
        if (sel < 4) op = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        else if (sel < 14) op = osp_pkg::CMD_SET_PAGE;
        else if (sel < 24) op = osp_pkg::CMD_SET_COL;
        else if (sel < 50) op = osp_pkg::CMD_WR_DATA;
        else begin
          case ($urandom_range(2))
            0:       op = osp_pkg::CMD_SET_PIX;
            1:       op = osp_pkg::CMD_CLR_PIX;
            default: op = osp_pkg::CMD_INV_PIX;
          endcase
        end
        // half the columns and rows land in small windows so bytes get revisited
        case ($urandom_range(3))
          0:       col = 7'($urandom_range(3));
          1:       col = 7'(124 + $urandom_range(3));
          default: col = 7'($urandom_range(127));
        endcase
        row = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
        drive_op(op, 3'($urandom_range(7)), col, row, 8'($urandom_range(255)),
                 1'b0, 3'd0, '0);
        if (op != CMD_UNUSED_6 && op != CMD_UNUSED_7) counted++;
      end
    end
    push <= 1'b0;
    // let the checker record the last op before looking at the queue
    @(posedge clk_i);

    // drain, then watch for stray beats
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/osp_pkg.sv
rtl/osp_front.sv
rtl/osp_back.sv
rtl/osp_out_fifo.sv
rtl/oled_shadow_pixel_writer.sv
verif/oled_shadow_pixel_writer_test.sv
